### rtl/approximate_pattern_matcher_defines.svh
// Assertion macros used by the approximate pattern matcher top level.
// Depends on nothing; expects a clock named clk and a reset named rst in scope.
`ifndef APPROXIMATE_PATTERN_MATCHER_DEFINES_SVH
`define APPROXIMATE_PATTERN_MATCHER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define APM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define APM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/apm_pkg.sv
// Shared types and constants for the approximate pattern matcher.
// Used by the channel interfaces, the cell row and the top level.
package apm_pkg;

  localparam int APM_MAX_PATTERN_DEF = 32;  // default number of cells
  localparam int LEN_W               = 6;   // pattern_length and max_errors
  localparam int CAP_W               = 7;   // max_errors + 1
  localparam int CHAR_W              = 8;
  localparam int PATTERN_CHARS       = 32;  // characters held by the registers
  localparam int PATTERN_BITS        = PATTERN_CHARS * CHAR_W;
  localparam int POS_W               = 32;
  localparam int START_W             = 33;
  localparam int CFG_INDEX_W         = 3;
  localparam int CFG_DATA_W          = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_MAX_ERRORS     = 3'd1,
    REG_PATTERN_CHARS0 = 3'd2,
    REG_PATTERN_CHARS1 = 3'd3,
    REG_PATTERN_CHARS2 = 3'd4,
    REG_PATTERN_CHARS3 = 3'd5
  } cfg_reg_t;

  // Control part of the wave that walks the cell row, one cell a cycle.
  typedef struct packed {
    logic              valid;
    logic              restart;
    logic [CHAR_W-1:0] ch;
  } wave_ctl_t;

endpackage

### rtl/apm_in_if.sv
// Text request channel of the approximate pattern matcher.
// Depends on apm_pkg for field widths.
interface apm_in_if import apm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_byte;
  logic              new_text;

  modport source (output valid, output text_byte, output new_text, input ready);
  modport sink   (input valid, input text_byte, input new_text, output ready);
endinterface

### rtl/apm_out_if.sv
// Result request channel of the approximate pattern matcher.
// Depends on apm_pkg for field widths.
interface apm_out_if import apm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      match;
  logic [LEN_W-1:0]          distance;
  logic [POS_W-1:0]          end_position;
  logic signed [START_W-1:0] start_position;

  modport source (output valid, output match, output distance, output end_position,
                  output start_position, input ready);
  modport sink   (input valid, input match, input distance, input end_position,
                  input start_position, output ready);
endinterface

### rtl/approximate_pattern_matcher.sv
// Approximate pattern matcher: takes one text byte per request and returns one
// result request per byte telling whether the configured pattern (up to
// MAX_PATTERN characters) ends at that byte with at most max_errors edits,
// together with the capped distance, the byte's position and the start
// estimate. The column of edit distances lives in a row of MAX_PATTERN cells;
// a byte travels down the row one cell per clock and then through the hold
// stage to the output register, and the block works on one byte at a time:
// a new byte is taken once the previous result has moved into the output
// register, which a stalled output delays. Configuration writes never touch
// the column or the position; write them only while idle.
// Depends on apm_pkg, apm_in_if, apm_out_if, apm_chain and the defines header.
`include "approximate_pattern_matcher_defines.svh"

module approximate_pattern_matcher import apm_pkg::*; #(
  parameter int MAX_PATTERN = APM_MAX_PATTERN_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  apm_in_if.sink                 text,
  apm_out_if.source              result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Entry width: reset values up to MAX_PATTERN, capped values up to 64.
  localparam int DW = ($clog2(MAX_PATTERN + 1) > CAP_W) ? $clog2(MAX_PATTERN + 1) : CAP_W;

  // Configuration registers.
  logic [LEN_W-1:0]      pattern_length;
  logic [LEN_W-1:0]      max_errors;
  logic [CFG_DATA_W-1:0] pattern_chars [4];

  // Control and position state.
  logic             busy;        // a byte is in the row or waiting in hold
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] end_pos;     // position of the byte in flight
  wave_ctl_t        wave_in;
  wave_ctl_t        wave_out;
  logic [DW-1:0]    last;
  logic             hold_valid;
  logic [DW-1:0]    hold_last;

  logic             accept;
  logic [POS_W-1:0] base_pos;
  logic [CAP_W-1:0] cap;
  logic [START_W-1:0] m_ext;
  logic             out_free;

  assign accept     = text.valid && text.ready;
  assign text.ready = !busy;
  assign cap        = {1'b0, max_errors} + CAP_W'(1);
  assign out_free   = !result.valid || result.ready;
  assign base_pos   = text.new_text ? '0 : byte_position;

  // Length in use, clamped to the number of cells.
  assign m_ext = (32'(pattern_length) > 32'(MAX_PATTERN)) ? START_W'(MAX_PATTERN)
                                                         : START_W'(pattern_length);

  // Configuration writes; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      max_errors     <= '0;
      for (int k = 0; k < 4; k++) begin
        pattern_chars[k] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length   <= cfg_data[LEN_W-1:0];
        REG_MAX_ERRORS:     max_errors       <= cfg_data[LEN_W-1:0];
        REG_PATTERN_CHARS0: pattern_chars[0] <= cfg_data;
        REG_PATTERN_CHARS1: pattern_chars[1] <= cfg_data;
        REG_PATTERN_CHARS2: pattern_chars[2] <= cfg_data;
        REG_PATTERN_CHARS3: pattern_chars[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Launch a byte into the row, advance the position and track the single
  // byte in flight until its result leaves the hold stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      byte_position <= '0;
      wave_in.valid <= 1'b0;
      hold_valid    <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      wave_in.valid <= accept;
      if (accept) begin
        busy          <= 1'b1;
        byte_position <= (&base_pos) ? base_pos : base_pos + POS_W'(1);
      end
      // Catch the wave at the end of the row.
      if (wave_out.valid) begin
        hold_valid <= 1'b1;
      end
      // Move the result to the output register when it is free.
      if (hold_valid && out_free) begin
        hold_valid   <= 1'b0;
        busy         <= 1'b0;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
    // Payload of the launched byte: no reset needed.
    if (accept) begin
      wave_in.restart <= text.new_text;
      wave_in.ch      <= text.text_byte;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      end_pos <= base_pos;
    end
    if (wave_out.valid) begin
      hold_last <= last;
    end
    if (hold_valid && out_free) begin
      result.match          <= (hold_last <= DW'(max_errors));
      result.distance       <= hold_last[LEN_W-1:0];
      result.end_position   <= end_pos;
      result.start_position <= $signed({1'b0, end_pos} - m_ext + START_W'(1));
    end
  end

  apm_chain #(
    .NCELL (MAX_PATTERN),
    .DW    (DW)
  ) u_chain (
    .clk            (clk),
    .rst            (rst),
    .wave_in        (wave_in),
    .pattern_length (pattern_length),
    .pattern_chars  ({pattern_chars[3], pattern_chars[2], pattern_chars[1],
                      pattern_chars[0]}),
    .cap            (cap),
    .wave_out       (wave_out),
    .last           (last)
  );

  // A waiting result always belongs to a byte still counted as in flight.
  `APM_ASSERT_SAME(a_hold_busy, hold_valid, busy, "hold stage full while not busy")
  // The wave must never find the hold stage occupied.
  `APM_ASSERT_SAME(a_tail_free, wave_out.valid, !hold_valid, "wave hit a full hold stage")
  // A new byte is only launched when the row is empty of earlier work.
  `APM_ASSERT_SAME(a_launch_idle, wave_in.valid, !hold_valid && !wave_out.valid,
                   "byte launched while another is in flight")
  // Accepting a byte closes the input until its result moves out.
  `APM_ASSERT_NEXT(a_accept_busy, accept, busy && !text.ready, "not busy after accept")
  // Leaving the hold stage presents a result and reopens the input.
  `APM_ASSERT_NEXT(a_hold_out, hold_valid && out_free, result.valid && !busy,
                   "result not presented after leaving hold")

endmodule

### rtl/apm_cell.sv
// One edit-distance cell: holds one column entry and updates it as the wave passes.
// Depends on apm_pkg for the wave control struct.
module apm_cell import apm_pkg::*; #(
  parameter int INDEX = 0,
  parameter int DW    = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  wave_ctl_t         ctl_in,
  input  logic [DW-1:0]     old_prev_in,
  input  logic [DW-1:0]     new_prev_in,
  input  logic              in_range,
  input  logic [CHAR_W-1:0] pat_char,
  input  logic [CAP_W-1:0]  cap,
  output wave_ctl_t         ctl_out,
  output logic [DW-1:0]     old_prev_out,
  output logic [DW-1:0]     new_prev_out
);

  localparam logic [DW-1:0] RESET_VAL = DW'(INDEX + 1);

  logic [DW-1:0] entry;
  logic [DW-1:0] old_here;
  logic [DW:0]   del_cost;
  logic [DW:0]   sub_cost;
  logic [DW:0]   ins_cost;
  logic [DW:0]   cap_ext;
  logic [DW:0]   min_a;
  logic [DW:0]   min_b;
  logic [DW:0]   v_full;
  logic [DW-1:0] v;

  always_comb begin
    old_here = ctl_in.restart ? RESET_VAL : entry;
    del_cost = {1'b0, old_here} + (DW+1)'(1);
    sub_cost = {1'b0, old_prev_in} + (DW+1)'(pat_char != ctl_in.ch);
    ins_cost = {1'b0, new_prev_in} + (DW+1)'(1);
    cap_ext  = (DW+1)'(cap);
    min_a    = (del_cost < sub_cost) ? del_cost : sub_cost;
    min_b    = (cap_ext < ins_cost) ? cap_ext : ins_cost;
    v_full   = (min_a < min_b) ? min_a : min_b;
    v        = v_full[DW-1:0];  // never above the cap, so it fits
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry         <= RESET_VAL;
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
      if (ctl_in.valid) begin
        entry <= in_range ? v : old_here;
      end
    end
    // Hand the wave to the next cell; out of range cells pass the last value on.
    ctl_out.restart <= ctl_in.restart;
    ctl_out.ch      <= ctl_in.ch;
    old_prev_out    <= old_here;
    new_prev_out    <= in_range ? v : new_prev_in;
  end

endmodule

### rtl/apm_chain.sv
// Row of edit-distance cells, wave entering at cell 0 and leaving after the last.
// Depends on apm_pkg and apm_cell.
module apm_chain import apm_pkg::*; #(
  parameter int NCELL = APM_MAX_PATTERN_DEF,
  parameter int DW    = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  wave_ctl_t               wave_in,
  input  logic [LEN_W-1:0]        pattern_length,
  input  logic [PATTERN_BITS-1:0] pattern_chars,
  input  logic [CAP_W-1:0]        cap,
  output wave_ctl_t               wave_out,
  output logic [DW-1:0]           last
);

  wave_ctl_t     ctl   [NCELL+1];
  logic [DW-1:0] old_p [NCELL+1];
  logic [DW-1:0] new_p [NCELL+1];

  // The entry before the pattern is always zero.
  assign ctl[0]   = wave_in;
  assign old_p[0] = '0;
  assign new_p[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [CHAR_W-1:0] pc;
    logic              in_range;

    if (i < PATTERN_CHARS) begin : g_char
      assign pc = pattern_chars[i*CHAR_W +: CHAR_W];
    end else begin : g_zero
      assign pc = '0;
    end

    assign in_range = (32'(pattern_length) > 32'(i));

    apm_cell #(
      .INDEX (i),
      .DW    (DW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl_in       (ctl[i]),
      .old_prev_in  (old_p[i]),
      .new_prev_in  (new_p[i]),
      .in_range     (in_range),
      .pat_char     (pc),
      .cap          (cap),
      .ctl_out      (ctl[i+1]),
      .old_prev_out (old_p[i+1]),
      .new_prev_out (new_p[i+1])
    );
  end

  assign wave_out = ctl[NCELL];
  assign last     = new_p[NCELL];

endmodule
